@@ sv/spq_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// shared constants, types and address helper for the stable priority queue
// no dependencies; used by the channel interfaces and the core

package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ID_W        = 16;
  localparam int PRIO_W      = 8;
  localparam int FILL_W      = 5;
  localparam int ENTRY_W     = ID_W + PRIO_W;

  // request codes
  localparam logic REQ_ENQUEUE = 1'b0;
  localparam logic REQ_DEQUEUE = 1'b1;

  typedef enum logic [1:0] {
    STATUS_ENQUEUED = 2'd0,
    STATUS_DEQUEUED = 2'd1,
    STATUS_EMPTY    = 2'd2,
    STATUS_FULL     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_CMP,
    S_DEQ,
    S_RES
  } state_t;

  // physical slot of a logical position counted from the head, circular
  function automatic logic [IDX_W-1:0] slot_addr(input logic [IDX_W-1:0] base,
                                                 input logic [IDX_W-1:0] ofs);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, ofs};
    if (sum >= (IDX_W + 1)'(QUEUE_DEPTH)) begin
      sum = sum - (IDX_W + 1)'(QUEUE_DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/spq_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// request channel: valid/ready handshake with enqueue/dequeue payload
// depends on spq_pkg for field widths

interface spq_req_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic              req_type;
  logic [ID_W-1:0]   proc_id;
  logic [PRIO_W-1:0] proc_priority;

  modport source (output valid, req_type, proc_id, proc_priority, input ready);
  modport sink   (input valid, req_type, proc_id, proc_priority, output ready);
endinterface

`default_nettype wire

@@ sv/spq_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// response channel: valid/ready handshake with status, entry and fill level
// depends on spq_pkg for field widths

interface spq_rsp_if;
  import spq_pkg::*;

  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [ID_W-1:0]   out_id;
  logic [PRIO_W-1:0] out_priority;
  logic [FILL_W-1:0] fill_level;

  modport source (output valid, status, out_id, out_priority, fill_level, input ready);
  modport sink   (input valid, status, out_id, out_priority, fill_level, output ready);
endinterface

`default_nettype wire

@@ sv/spq_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies

module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ sv/stable_priority_queue_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// stable priority queue core: sequencer, circular slot store and result register
// depends on spq_pkg, spq_req_if, spq_rsp_if and spq_ram

// Bounded priority queue of process tags, held sorted from highest priority
// (front) to lowest in a circular slot ram with a head pointer. An enqueue is
// inserted behind every entry of equal or higher priority, so equal
// priorities leave in arrival order; a dequeue returns the front entry.
// Every request transfer yields exactly one response transfer. Timing is set
// by the single ram read port and the one shared priority comparator: an
// enqueue walks from the tail towards the front, one read state and one
// compare state per stored entry of lower priority that it passes, then the
// result state; a dequeue reads the front entry and then goes to the result
// state; an empty or full report goes straight to the result state. The next
// request is taken once the result has been handed to the output register,
// even while that result still waits for its transfer. The slot ram needs no
// clearing after reset: only slots inside the current fill are ever used.

module stable_priority_queue_core (
  input wire logic clk,
  input wire logic rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);
  import spq_pkg::*;

  state_t             state;
  state_t             state_next;

  logic [IDX_W-1:0]   head;         // physical slot of the front entry
  logic [CNT_W-1:0]   count;        // entries held
  logic [CNT_W-1:0]   pos;          // logical hole being filled during insert
  logic [ID_W-1:0]    new_id;
  logic [PRIO_W-1:0]  new_prio;

  // pending result, waiting for the output register
  status_t            res_status;
  logic [ID_W-1:0]    res_id;
  logic [PRIO_W-1:0]  res_prio;

  // output register
  logic               rsp_valid;
  status_t            rsp_status;
  logic [ID_W-1:0]    rsp_id;
  logic [PRIO_W-1:0]  rsp_prio;
  logic [FILL_W-1:0]  rsp_fill;

  // ram port
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic [ENTRY_W-1:0] wr_data;
  logic [IDX_W-1:0]   rd_addr;
  logic [ENTRY_W-1:0] rd_data;

  logic [ID_W-1:0]    rd_id;
  logic [PRIO_W-1:0]  rd_prio;
  logic [IDX_W-1:0]   pos_idx;
  logic [IDX_W-1:0]   pos_prev_idx;
  logic               in_xfer;
  logic               load_rsp;
  logic               cmp_stop;     // shared comparator: stored entry stays ahead

  assign rd_id        = rd_data[ENTRY_W-1 -: ID_W];
  assign rd_prio      = rd_data[PRIO_W-1:0];
  assign pos_idx      = IDX_W'(pos);
  assign pos_prev_idx = IDX_W'(pos - CNT_W'(1));
  assign cmp_stop     = (rd_prio >= new_prio);
  assign in_xfer      = req.valid && req.ready;
  assign load_rsp     = (state == S_RES) && (!rsp_valid || rsp.ready);

  spq_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_slots (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_xfer) begin
          if (req.req_type == REQ_DEQUEUE) begin
            state_next = (count == '0) ? S_RES : S_DEQ;
          end else begin
            state_next = (count == CNT_W'(QUEUE_DEPTH)) ? S_RES : S_SCAN;
          end
        end
      end
      S_SCAN: state_next = (pos == '0) ? S_RES : S_CMP;
      S_CMP:  state_next = cmp_stop ? S_RES : S_SCAN;
      S_DEQ:  state_next = S_RES;
      S_RES:  state_next = load_rsp ? S_IDLE : S_RES;
      default: state_next = S_IDLE;
    endcase
  end

  // ram control and handshake
  always_comb begin
    req.ready = (state == S_IDLE);
    wr_en     = 1'b0;
    wr_addr   = slot_addr(head, pos_idx);
    wr_data   = {new_id, new_prio};
    rd_addr   = head;
    case (state)
      S_SCAN: begin
        rd_addr = slot_addr(head, pos_prev_idx);
        // reached the front: new entry becomes the head entry
        wr_en   = (pos == '0);
      end
      S_CMP: begin
        wr_en = 1'b1;
        // lower-priority entry moves back by one, otherwise the new one lands
        if (!cmp_stop) begin
          wr_data = rd_data;
        end
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (in_xfer) begin
            new_id   <= req.proc_id;
            new_prio <= req.proc_priority;
            pos      <= count;
            res_id   <= '0;
            res_prio <= '0;
            if (req.req_type == REQ_DEQUEUE) begin
              res_status <= (count == '0) ? STATUS_EMPTY : STATUS_DEQUEUED;
            end else begin
              res_status <= (count == CNT_W'(QUEUE_DEPTH)) ? STATUS_FULL
                                                            : STATUS_ENQUEUED;
            end
          end
        end
        S_SCAN: begin
          if (pos == '0) begin
            count <= count + CNT_W'(1);
          end
        end
        S_CMP: begin
          if (cmp_stop) begin
            count <= count + CNT_W'(1);
          end else begin
            pos <= pos - CNT_W'(1);
          end
        end
        S_DEQ: begin
          res_id   <= rd_id;
          res_prio <= rd_prio;
          count    <= count - CNT_W'(1);
          head     <= (head == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + IDX_W'(1);
        end
        default: begin
        end
      endcase

      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // output payload, no reset needed
  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_status <= res_status;
      rsp_id     <= res_id;
      rsp_prio   <= res_prio;
      rsp_fill   <= FILL_W'(count);
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.status       = rsp_status;
  assign rsp.out_id       = rsp_id;
  assign rsp.out_priority = rsp_prio;
  assign rsp.fill_level   = rsp_fill;

endmodule

`default_nettype wire

@@ tb/sv/spq_tb_pkg.sv @@
`timescale 1ns / 1ps
// scoreboard for the stable priority queue: expected order and result check
// depends on spq_pkg for widths, request codes and status codes

package spq_tb_pkg;
  import spq_pkg::*;

  typedef struct {
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } held_entry_t;

  typedef struct {
    status_t           status;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
    logic [FILL_W-1:0] fill;
  } queue_result_t;

  class queue_order_checker;
    // sorted copy of the queue, front first
    held_entry_t   held[$];
    // results owed by the block, oldest first
    queue_result_t owed[$];
    int            mismatches = 0;

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      mismatches++;
    endtask

    function int outstanding();
      return owed.size();
    endfunction

    // work out the result of an accepted request and update the queue copy
    function void note_request(logic req_type, logic [ID_W-1:0] id,
                               logic [PRIO_W-1:0] prio);
      queue_result_t r;
      held_entry_t   e;
      int            pos;
      r.id   = '0;
      r.prio = '0;
      if (req_type == REQ_ENQUEUE) begin
        if (held.size() >= QUEUE_DEPTH) begin
          r.status = STATUS_FULL;
        end else begin
          // behind every entry of equal or higher priority
          pos = 0;
          while (pos < held.size() && held[pos].prio >= prio) pos++;
          e.id   = id;
          e.prio = prio;
          held.insert(pos, e);
          r.status = STATUS_ENQUEUED;
        end
      end else if (held.size() == 0) begin
        r.status = STATUS_EMPTY;
      end else begin
        e = held.pop_front();
        r.status = STATUS_DEQUEUED;
        r.id     = e.id;
        r.prio   = e.prio;
      end
      r.fill = FILL_W'(held.size());
      owed.push_back(r);
    endfunction

    task check_result(status_t status, logic [ID_W-1:0] id,
                      logic [PRIO_W-1:0] prio, logic [FILL_W-1:0] fill);
      queue_result_t r;
      if (owed.size() == 0) begin
        report($sformatf("result transfer with none outstanding (status %0d)", status));
      end else begin
        r = owed.pop_front();
        if (status !== r.status)
          report($sformatf("status %0d, expected %0d", status, r.status));
        if (id !== r.id)
          report($sformatf("out_id %h, expected %h", id, r.id));
        if (prio !== r.prio)
          report($sformatf("out_priority %h, expected %h", prio, r.prio));
        if (fill !== r.fill)
          report($sformatf("fill_level %0d, expected %0d", fill, r.fill));
      end
    endtask
  endclass

endpackage

@@ tb/sv/stable_priority_queue_core_tb.sv @@
`timescale 1ns / 1ps
// testbench for stable_priority_queue_core: directed and random request traffic
// depends on spq_pkg, spq_req_if, spq_rsp_if, spq_tb_pkg and the core

module stable_priority_queue_core_tb;
  import spq_pkg::*;
  import spq_tb_pkg::*;

  // cycles without any transfer before the run is abandoned
  localparam int IDLE_LIMIT    = 3000;
  // room for the longest enqueue, which walks the whole queue, plus margin
  localparam int SETTLE_CYCLES = 3 + 2 * QUEUE_DEPTH + 8;
  localparam int RANDOM_ITEMS  = 550;

  logic clk = 1'b0;
  logic rst;
  int   idle_cycles = 0;

  spq_req_if req_ch ();
  spq_rsp_if rsp_ch ();

  queue_order_checker order_check = new();

  stable_priority_queue_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // sender side: bursts of back-to-back transfers separated by random gaps
  // ---------------------------------------------------------------------------
  int burst_left;
  bit gaps_on;

  // present one request and hold it until the transfer happens
  task automatic send_request(logic req_type, logic [ID_W-1:0] id,
                              logic [PRIO_W-1:0] prio);
    int gap;
    req_ch.valid         <= 1'b1;
    req_ch.req_type      <= req_type;
    req_ch.proc_id       <= id;
    req_ch.proc_priority <= prio;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    order_check.note_request(req_type, id, prio);
    // valid is only lowered when a gap follows, never dropped and raised in one step
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 12);
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sender holds off until every owed result has come back
  task automatic wait_for_drain();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (order_check.outstanding() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // receiver side: ready follows a repeating 16-bit pattern that is swapped every so often
  // ---------------------------------------------------------------------------
  initial begin
    logic [15:0] ready_pattern;
    int          tick;
    ready_pattern = 16'hffff;
    tick          = 0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (tick % 48 == 0) begin
        case ($urandom_range(0, 3))
          0:       ready_pattern = 16'hffff;                  // no stalls at all
          1:       ready_pattern = 16'($urandom) & 16'($urandom); // heavy stalling
          default: ready_pattern = 16'($urandom);
        endcase
        if (ready_pattern == 16'h0000) ready_pattern = 16'h0001;
      end
      rsp_ch.ready <= ready_pattern[tick % 16];
      tick++;
    end
  end

  // ---------------------------------------------------------------------------
  // result check and watchdog, both sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      order_check.check_result(status_t'(rsp_ch.status), rsp_ch.out_id,
                               rsp_ch.out_priority, rsp_ch.fill_level);
    end
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  // sixteen entries that fill the queue: extreme ids and priorities, and ties
  // at the top, the bottom and the middle to check arrival order is kept
  logic [ID_W+PRIO_W-1:0] fill_set [16] = '{
    {16'h0000, 8'h00}, {16'hffff, 8'hff}, {16'h1234, 8'h80}, {16'h0001, 8'h80},
    {16'h0002, 8'h80}, {16'haaaa, 8'hff}, {16'h5555, 8'h00}, {16'h8000, 8'h7f},
    {16'h7fff, 8'h81}, {16'h0fff, 8'h01}, {16'hf000, 8'hfe}, {16'h00ff, 8'h80},
    {16'hff00, 8'h80}, {16'h0100, 8'h00}, {16'h0200, 8'hff}, {16'h0300, 8'h40}
  };

  initial begin
    int               enq_pct;
    int               phase_left;
    logic             kind;
    logic [PRIO_W-1:0] prio;

    rst                  <= 1'b1;
    req_ch.valid         <= 1'b0;
    req_ch.req_type      <= REQ_ENQUEUE;
    req_ch.proc_id       <= '0;
    req_ch.proc_priority <= '0;
    burst_left = $urandom_range(1, 12);
    gaps_on    = 1'b1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: dequeue while empty, fill to the brim, one enqueue past full
    send_request(REQ_DEQUEUE, 16'hffff, 8'hff);
    foreach (fill_set[i]) begin
      send_request(REQ_ENQUEUE, fill_set[i][ID_W+PRIO_W-1:PRIO_W], fill_set[i][PRIO_W-1:0]);
    end
    send_request(REQ_ENQUEUE, 16'hbeef, 8'hff);
    // a few dequeues with junk payload, which must be ignored
    repeat (5) send_request(REQ_DEQUEUE, 16'($urandom), 8'($urandom));
    wait_for_drain();

    // random: phases that lean towards filling or draining so that the full
    // and empty ends are both reached again and again
    enq_pct    = 50;
    phase_left = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (phase_left == 0) begin
        phase_left = $urandom_range(15, 60);
        case ($urandom_range(0, 3))
          0:       enq_pct = 20;
          1:       enq_pct = 85;
          default: enq_pct = 55;
        endcase
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      phase_left--;

      kind = ($urandom_range(0, 99) < enq_pct) ? REQ_ENQUEUE : REQ_DEQUEUE;
      // clustered priorities make ties common
      case ($urandom_range(0, 3))
        0:       prio = PRIO_W'($urandom_range(0, 3));
        1:       prio = 8'hff - PRIO_W'($urandom_range(0, 2));
        2:       prio = 8'h80 + PRIO_W'($urandom_range(0, 1));
        default: prio = PRIO_W'($urandom);
      endcase
      send_request(kind, ID_W'($urandom), prio);

      // one hold-off in the middle of the random traffic
      if (n == RANDOM_ITEMS / 2) wait_for_drain();
    end

    // let everything come home, then give a stray result time to show up
    req_ch.valid <= 1'b0;
    while (order_check.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (order_check.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
